// ===== rtl/rws_pkg.sv =====
// Package for the congestion-controlled segment sender.
// Shared types, register indexes, reset values and small helper functions.
// No dependencies.
package rws_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CFG_SEG_BYTES = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SSTHRESH  = 2'd2;

  localparam int DefWindowDepth = 64;

  localparam logic [10:0] SegReset   = 11'd500;
  localparam logic [15:0] TicksReset = 16'd500;
  localparam logic [23:0] SsthReset  = 24'd8000;

  localparam logic [7:0] AckTypeCode = 8'h01;

  localparam logic [1:0] PH_SLOW  = 2'd0;
  localparam logic [1:0] PH_AVOID = 2'd1;
  localparam logic [1:0] PH_FAST  = 2'd2;

  localparam int DivNumW = 38;
  localparam int DivDenW = 32;

  typedef struct packed {
    logic        cmd;
    logic [31:0] total;
    logic        ack_ok;
    logic [7:0]  ack_seq;
    logic [31:0] now;
  } rws_item_t;

  function automatic logic [7:0] fold8(input logic [8:0] s);
    logic [8:0] t;
    t = {8'd0, s[8]} + {1'b0, s[7:0]};
    t = {8'd0, t[8]} + {1'b0, t[7:0]};
    return t[7:0];
  endfunction

  function automatic logic ack_sum_ok(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] s;
    s = fold8({1'b0, a} + {1'b0, b});
    s = fold8({1'b0, s} + {1'b0, c});
    return s == 8'hFF;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [38:0] b);
    logic [39:0] s;
    s = {8'd0, a} + {1'b0, b};
    return (s[39:32] != 8'd0) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ===== rtl/rws_front.sv =====
// Front end: takes start transactions, checks the acknowledgement bytes
// and pushes a classified item into the queue. Depends on rws_pkg.
module rws_front (
  input  logic              start,
  output logic              busy,
  input  logic              cmd_i,
  input  logic [31:0]       total_bytes_i,
  input  logic              ack_present_i,
  input  logic [7:0]        ack_checksum_i,
  input  logic [7:0]        ack_type_i,
  input  logic [7:0]        ack_seq_i,
  input  logic [31:0]       now_i,
  input  logic              full_i,
  output logic              push_o,
  output rws_pkg::rws_item_t item_o
);
  import rws_pkg::*;

  assign busy   = full_i;
  assign push_o = start && !full_i;

  always_comb begin
    item_o.cmd     = cmd_i;
    item_o.total   = total_bytes_i;
    item_o.ack_ok  = ack_present_i && (ack_type_i == AckTypeCode) &&
                     ack_sum_ok(ack_checksum_i, ack_type_i, ack_seq_i);
    item_o.ack_seq = ack_seq_i;
    item_o.now     = now_i;
  end

endmodule

// ===== rtl/rws_fifo.sv =====
// Two-entry queue of classified items between front and back end.
// Depends on rws_pkg.
module rws_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rws_pkg::rws_item_t din_i,
  input  logic               pop_i,
  output rws_pkg::rws_item_t dout_o,
  output logic               full_o,
  output logic               empty_o
);
  import rws_pkg::*;

  rws_item_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign dout_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= din_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== rtl/rws_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Shared by segment count and window growth. Depends on rws_pkg.
module rws_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rws_pkg::DivNumW-1:0] num_i,
  input  logic [rws_pkg::DivDenW-1:0] den_i,
  output logic                        done_o,
  output logic [rws_pkg::DivNumW-1:0] quot_o,
  output logic [rws_pkg::DivDenW-1:0] rem_o
);
  import rws_pkg::*;

  localparam int CntW = $clog2(DivNumW + 1);

  logic [DivNumW-1:0] q_q;
  logic [DivDenW-1:0] r_q, den_q;
  logic [CntW-1:0]    cnt_q;
  logic               run_q, done_q;
  logic [DivDenW:0]   trial;
  logic               fits;

  assign trial  = {r_q, q_q[DivNumW-1]};
  assign fits   = trial >= {1'b0, den_q};
  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      r_q   <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      q_q <= {q_q[DivNumW-2:0], fits};
      r_q <= fits ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(DivNumW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/rws_back.sv =====
// Back end: window state, send decision, ACK retire, timeout and the
// send-time memory. Depends on rws_pkg and rws_div.
module rws_back #(
  parameter int WINDOW_DEPTH = rws_pkg::DefWindowDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [rws_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rws_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         empty_i,
  input  rws_pkg::rws_item_t           item_i,
  output logic                         pop_o,
  output logic                         res_valid_o,
  output logic                         send_valid_o,
  output logic [31:0]                  send_index_o,
  output logic [7:0]                   send_seq_o,
  output logic                         send_is_last_o,
  output logic [10:0]                  send_length_o,
  output logic                         ack_accepted_o,
  output logic                         timed_out_o,
  output logic [1:0]                   phase_o,
  output logic [23:0]                  cwnd_bytes_o,
  output logic [23:0]                  ssthresh_bytes_o,
  output logic                         done_res_o
);
  import rws_pkg::*;

  localparam int HW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = CW + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_RECV = 3'd2;
  localparam logic [2:0] ST_SDIV = 3'd3;
  localparam logic [2:0] ST_ADIV = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  st_q, st_d;
  logic [10:0] seg_q, seg_d;
  logic [15:0] ticks_q, ticks_d;
  logic [31:0] cwnd_q, cwnd_d;
  logic [23:0] ss_q, ss_d;
  logic [1:0]  dup_q, dup_d;
  logic [7:0]  base_q, base_d, nseq_q, nseq_d, last_q, last_d;
  logic [31:0] nidx_q, nidx_d, acked_q, acked_d, tsegs_q, tsegs_d;
  logic [10:0] tail_q, tail_d;
  logic [HW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  rws_item_t   it_q, it_d;
  logic        sv_q, sv_d, slast_q, slast_d, acc_q, acc_d, tout_q, tout_d;
  logic        empty_q, empty_d;
  logic [31:0] sidx_q, sidx_d;
  logic [7:0]  sseq_q, sseq_d;
  logic [10:0] slen_q, slen_d;

  logic        rv_q, rv_d;
  logic [1:0]  rph_q, rph_d;

  logic [31:0] tmem [WINDOW_DEPTH];
  logic [31:0] rd_q;

  logic                div_start, div_done;
  logic [DivNumW-1:0]  div_num, div_quot;
  logic [DivDenW-1:0]  div_den, div_rem;

  // combinational helpers
  logic [1:0]    ph;
  logic [7:0]    off;
  logic          hit, dupack, dup3, tmo, xfer_done, send_ok;
  logic [31:0]   seg_fx, cwnd_slow, cwnd_dup3, cwnd_a, oldest;
  logic [12:0]   seg3;
  logic [21:0]   seg_sq;
  logic [CW-1:0] cnt_a, k;
  logic [SW-1:0] tail_sum, head_sum;
  logic [HW-1:0] tail_idx, head_ret;
  logic [CW+10:0] win_prod;
  logic          we;

  rws_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  assign ph = (dup_q == 2'd3) ? PH_FAST :
              (cwnd_q < {ss_q, 8'd0}) ? PH_SLOW : PH_AVOID;
  assign xfer_done = acked_q == tsegs_q;
  assign seg_fx    = {13'd0, seg_q, 8'd0};
  assign seg3      = {2'd0, seg_q} + {1'b0, seg_q, 1'b0};
  assign seg_sq    = {11'd0, seg_q} * {11'd0, seg_q};

  assign win_prod = cnt_q * seg_q;
  assign send_ok  = (32'({win_prod, 8'd0}) < cwnd_q) && (nidx_q < tsegs_q) &&
                    (cnt_q < CW'(WINDOW_DEPTH));
  assign tail_sum = {1'b0, cnt_q} + SW'(head_q);
  assign tail_idx = (tail_sum >= SW'(WINDOW_DEPTH)) ?
                    HW'(tail_sum - SW'(WINDOW_DEPTH)) : HW'(tail_sum);
  assign we = (st_q == ST_EXEC) && it_q.cmd && !xfer_done && send_ok;

  assign off    = it_q.ack_seq - base_q;
  assign hit    = it_q.ack_ok && (off < 8'(cnt_q));
  assign dupack = it_q.ack_ok && !hit && (it_q.ack_seq == last_q);
  assign dup3   = dupack && (ph != PH_FAST) && (dup_q == 2'd2);
  assign k      = CW'(off) + CW'(1);
  assign head_sum = {1'b0, k} + SW'(head_q);
  assign head_ret = (head_sum >= SW'(WINDOW_DEPTH)) ?
                    HW'(head_sum - SW'(WINDOW_DEPTH)) : HW'(head_sum);

  assign cwnd_slow = sat_add(cwnd_q, 39'(seg_fx));
  assign cwnd_dup3 = sat_add({1'b0, cwnd_q[31:9], 8'd0}, {18'd0, seg3, 8'd0});
  assign cwnd_a    = !dupack ? cwnd_q : (ph == PH_FAST) ? cwnd_slow :
                     dup3 ? cwnd_dup3 : cwnd_q;
  assign cnt_a     = dup3 ? '0 : cnt_q;
  assign oldest    = empty_q ? it_q.now : rd_q;
  assign tmo       = (cnt_a != '0) && ((it_q.now - oldest) > {16'd0, ticks_q});

  assign pop_o = (st_q == ST_IDLE) && !empty_i;

  always_ff @(posedge clk_i) begin
    if (we) tmem[tail_idx] <= it_q.now;
    rd_q <= tmem[head_q];
  end

  always_comb begin
    st_d = st_q; seg_d = seg_q; ticks_d = ticks_q; cwnd_d = cwnd_q; ss_d = ss_q;
    dup_d = dup_q; base_d = base_q; nseq_d = nseq_q; last_d = last_q;
    nidx_d = nidx_q; acked_d = acked_q; tsegs_d = tsegs_q; tail_d = tail_q;
    head_d = head_q; cnt_d = cnt_q; it_d = it_q;
    sv_d = sv_q; slast_d = slast_q; acc_d = acc_q; tout_d = tout_q;
    empty_d = empty_q; sidx_d = sidx_q; sseq_d = sseq_q; slen_d = slen_q;
    rv_d = 1'b0; rph_d = rph_q;
    div_start = 1'b0;
    div_num = {6'd0, it_q.total};
    div_den = {21'd0, seg_q};

    case (st_q)
      ST_IDLE: begin
        if (!empty_i) begin
          it_d = item_i;
          st_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        sv_d = 1'b0; sidx_d = '0; sseq_d = '0; slast_d = 1'b0; slen_d = '0;
        acc_d = 1'b0; tout_d = 1'b0;
        if (!it_q.cmd) begin
          if (seg_q == '0) begin
            tsegs_d = '0; tail_d = '0;
            nidx_d = '0; acked_d = '0; head_d = '0; cnt_d = '0;
            nseq_d = base_q; last_d = base_q - 8'd1;
            st_d = ST_OUT;
          end else begin
            div_start = 1'b1;
            st_d = ST_SDIV;
          end
        end else if (xfer_done) begin
          st_d = ST_OUT;
        end else begin
          empty_d = cnt_q == '0;
          if (send_ok) begin
            sv_d    = 1'b1;
            sidx_d  = nidx_q;
            sseq_d  = nseq_q;
            slast_d = nidx_q == tsegs_q - 32'd1;
            slen_d  = (nidx_q == tsegs_q - 32'd1) ? tail_q : seg_q;
            cnt_d   = cnt_q + CW'(1);
            nseq_d  = nseq_q + 8'd1;
            nidx_d  = nidx_q + 32'd1;
          end
          st_d = ST_RECV;
        end
      end
      ST_SDIV: begin
        if (div_done) begin
          tsegs_d = div_quot[31:0] + {31'd0, div_rem != '0};
          tail_d  = (div_rem != '0) ? div_rem[10:0] : seg_q;
          nidx_d = '0; acked_d = '0; head_d = '0; cnt_d = '0;
          nseq_d = base_q; last_d = base_q - 8'd1;
          st_d = ST_OUT;
        end
      end
      ST_RECV: begin
        st_d = ST_OUT;
        if (hit) begin
          acc_d   = 1'b1;
          head_d  = head_ret;
          cnt_d   = cnt_q - k;
          base_d  = base_q + 8'(k);
          acked_d = acked_q + 32'(k);
          last_d  = it_q.ack_seq;
          dup_d   = 2'd0;
          case (ph)
            PH_SLOW: cwnd_d = cwnd_slow;
            PH_AVOID: begin
              div_start = 1'b1;
              div_num   = {seg_sq, 16'd0};
              div_den   = (cwnd_q != '0) ? cwnd_q : 32'd1;
              st_d      = ST_ADIV;
            end
            default: cwnd_d = {ss_q, 8'd0};
          endcase
        end else begin
          cwnd_d = cwnd_a;
          if (dupack && ph != PH_FAST) dup_d = dup_q + 2'd1;
          if (dup3) ss_d = {1'b0, cwnd_q[31:9]};
          if (dup3 || tmo) begin
            nidx_d = nidx_q - 32'(cnt_q);
            cnt_d  = '0;
            head_d = '0;
            nseq_d = base_q;
          end
          if (tmo) begin
            ss_d   = {1'b0, cwnd_a[31:9]};
            cwnd_d = seg_fx;
            dup_d  = 2'd0;
            tout_d = 1'b1;
          end
        end
      end
      ST_ADIV: begin
        if (div_done) begin
          cwnd_d = sat_add(cwnd_q, {1'b0, div_quot});
          st_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        rv_d  = 1'b1;
        rph_d = ph;
        st_d  = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SEG_BYTES: seg_d   = cfg_data_i[10:0];
        CFG_TIMEOUT:   ticks_d = cfg_data_i[15:0];
        CFG_SSTHRESH:  ss_d    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; sidx_q <= sidx_d; sseq_q <= sseq_d; slen_q <= slen_d;
    slast_q <= slast_d; sv_q <= sv_d; acc_q <= acc_d; tout_q <= tout_d;
    empty_q <= empty_d; rph_q <= rph_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; seg_q <= SegReset; ticks_q <= TicksReset;
      cwnd_q <= {13'd0, SegReset, 8'd0}; ss_q <= SsthReset; dup_q <= '0;
      base_q <= 8'd1; nseq_q <= 8'd1; last_q <= '0; nidx_q <= '0;
      acked_q <= '0; tsegs_q <= '0; tail_q <= '0; head_q <= '0; cnt_q <= '0;
      rv_q <= 1'b0;
    end else begin
      st_q <= st_d; seg_q <= seg_d; ticks_q <= ticks_d; cwnd_q <= cwnd_d;
      ss_q <= ss_d; dup_q <= dup_d; base_q <= base_d; nseq_q <= nseq_d;
      last_q <= last_d; nidx_q <= nidx_d; acked_q <= acked_d;
      tsegs_q <= tsegs_d; tail_q <= tail_d; head_q <= head_d; cnt_q <= cnt_d;
      rv_q <= rv_d;
    end
  end

  // results hold the state after the item, sampled in the output cycle
  logic [23:0] cwnd_res_q, ss_res_q;
  logic        done_res_q;
  always_ff @(posedge clk_i) begin
    cwnd_res_q <= cwnd_q[31:8];
    ss_res_q   <= ss_q;
    done_res_q <= xfer_done;
  end

  assign res_valid_o      = rv_q;
  assign send_valid_o     = sv_q;
  assign send_index_o     = sidx_q;
  assign send_seq_o       = sseq_q;
  assign send_is_last_o   = slast_q;
  assign send_length_o    = slen_q;
  assign ack_accepted_o   = acc_q;
  assign timed_out_o      = tout_q;
  assign phase_o          = rph_q;
  assign cwnd_bytes_o     = cwnd_res_q;
  assign ssthresh_bytes_o = ss_res_q;
  assign done_res_o       = done_res_q;

endmodule

// ===== rtl/reno_window_sender.sv =====
// Congestion-controlled segment sender, top level.
// Instantiates rws_front, rws_fifo and rws_back; depends on rws_pkg.
//
// Usage:
//  - Command channel: a transaction is taken at a clock edge with start high
//    and busy low. cmd_i 0 opens a transfer of total_bytes_i, cmd_i 1 runs one
//    send/receive pass with the ACK bytes and the current time now_i.
//  - Each transaction yields one result, shown for one cycle with
//    res_valid_o high. The receiver cannot stall; results are not held.
//  - A pass runs the execute, receive and output states; a start with a
//    nonzero segment size or an accepted ACK in congestion avoidance waits
//    for the 38-step serial divider (one quotient bit per cycle).
//  - The back end handles one item at a time; a two-entry queue lets the
//    front take up to two more while it works, busy rises when it is full.
//  - Configuration: cfg_valid_i with cfg_index_i and cfg_data_i, always
//    ready; write only while the block is idle. Index 0 segment bytes,
//    1 timeout ticks, 2 initial ssthresh (also loads ssthresh).
//  - Reset: asynchronous, active low; registers and window state return to
//    their defaults, the queue empties. No clearing pass is needed.
module reno_window_sender #(
  parameter int WINDOW_DEPTH = rws_pkg::DefWindowDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd_i,
  input  logic [31:0]                  total_bytes_i,
  input  logic                         ack_present_i,
  input  logic [7:0]                   ack_checksum_i,
  input  logic [7:0]                   ack_type_i,
  input  logic [7:0]                   ack_seq_i,
  input  logic [31:0]                  now_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rws_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rws_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         res_valid_o,
  output logic                         send_valid_o,
  output logic [31:0]                  send_index_o,
  output logic [7:0]                   send_seq_o,
  output logic                         send_is_last_o,
  output logic [10:0]                  send_length_o,
  output logic                         ack_accepted_o,
  output logic                         timed_out_o,
  output logic [1:0]                   phase_o,
  output logic [23:0]                  cwnd_bytes_o,
  output logic [23:0]                  ssthresh_bytes_o,
  output logic                         done_res_o
);
  import rws_pkg::*;

  rws_item_t push_item, pop_item;
  logic      push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  rws_front u_front (
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .total_bytes_i  (total_bytes_i),
    .ack_present_i  (ack_present_i),
    .ack_checksum_i (ack_checksum_i),
    .ack_type_i     (ack_type_i),
    .ack_seq_i      (ack_seq_i),
    .now_i          (now_i),
    .full_i         (full),
    .push_o         (push),
    .item_o         (push_item)
  );

  rws_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (push_item),
    .pop_i   (pop),
    .dout_o  (pop_item),
    .full_o  (full),
    .empty_o (empty)
  );

  rws_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .empty_i          (empty),
    .item_i           (pop_item),
    .pop_o            (pop),
    .res_valid_o      (res_valid_o),
    .send_valid_o     (send_valid_o),
    .send_index_o     (send_index_o),
    .send_seq_o       (send_seq_o),
    .send_is_last_o   (send_is_last_o),
    .send_length_o    (send_length_o),
    .ack_accepted_o   (ack_accepted_o),
    .timed_out_o      (timed_out_o),
    .phase_o          (phase_o),
    .cwnd_bytes_o     (cwnd_bytes_o),
    .ssthresh_bytes_o (ssthresh_bytes_o),
    .done_res_o       (done_res_o)
  );

endmodule

// ===== rtl/rws_checker.sv =====
// Port-level checks for the segment sender, bound to the top level.
// Uses no package.
module rws_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic                         res_valid_o,
  input logic                         send_valid_o,
  input logic [31:0]                  send_index_o,
  input logic [7:0]                   send_seq_o,
  input logic                         send_is_last_o,
  input logic [10:0]                  send_length_o,
  input logic                         ack_accepted_o,
  input logic                         timed_out_o
);

  a_no_send_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !send_valid_o |-> send_index_o == 32'd0 &&
      send_seq_o == 8'd0 && !send_is_last_o && send_length_o == 11'd0)
    else $error("send fields not clear without a send");

  a_tmo_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(timed_out_o && ack_accepted_o))
    else $error("timeout and accepted ACK in the same transaction");

  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobes in consecutive cycles");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind reno_window_sender rws_checker u_rws_checker (.*);
